### rtl/core/tfc_pkg.sv
package tfc_pkg;

  // Frame layout
  localparam int unsigned HeaderLen  = 3;
  localparam int unsigned PayloadLen = 14;
  localparam int unsigned FrameLen   = HeaderLen + PayloadLen + 1;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned PayloadW   = 8 * PayloadLen;

  localparam logic [7:0] LENGTH_BYTE = 8'(PayloadLen);

  // Reset values of the configuration registers
  localparam logic [7:0] START_BYTE_RST = 8'hA5;
  localparam logic [7:0] VERSION_RST    = 8'h01;
  localparam logic [1:0] CONN_CODE_RST  = 2'd2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_VERSION    = 2'd1,
    CFG_CONN_CODE  = 2'd2
  } cfg_idx_t;

  // Input request kind (carried in tuser)
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_LINK = 1'b1
  } op_t;

  // Result kind (carried in tuser)
  typedef enum logic [1:0] {
    OUT_OK      = 2'd0,
    OUT_BAD_LEN = 2'd1,
    OUT_BAD_SUM = 2'd2,
    OUT_LINK    = 2'd3
  } outcome_t;

  // Event handed to the status keeper for one accepted request
  typedef enum logic [2:0] {
    EV_NONE,
    EV_OK,
    EV_BAD_LEN,
    EV_BAD_SUM,
    EV_LINK
  } event_t;

  // Verdict of the frame tracker for the current byte
  typedef struct packed {
    logic frame_end;
    logic bad_len;
    logic bad_sum;
  } verdict_t;

  // One result as it leaves the status keeper
  typedef struct packed {
    outcome_t              outcome;
    logic [31:0]           count;
    logic                  valid;
    logic [1:0]            link;
    logic [PayloadW-1:0]   payload;
  } result_t;

endpackage

### rtl/core/telemetry_frame_checker.sv
// Telemetry frame checker. Takes one request per cycle: a frame byte (tuser 0,
// tlast on the final byte of a notification) or a link state update (tuser 1).
// A frame is good when byte 0 matches start_byte, byte 1 matches
// protocol_version, byte 2 is 14, at least 18 bytes arrive and bytes 0..17 XOR
// to zero; bytes past the 18th are ignored. Each final byte and each link
// update yields one result in the cycle after acceptance: the outcome in tuser and
// in tdata the wrapped 32-bit counter of that outcome (zero for a link update),
// the valid flag, the link code and the decoded little-endian fields of the last
// good payload. Every request is handled by the frame tracker and status keeper;
// throughput is one request per clock, limited only by the one-entry result
// register, which accepts a new request whenever it is empty or being drained.
// Configuration writes are always ready and should be issued while idle.
module telemetry_frame_checker (
  input  logic          clk,
  input  logic          rst_n,
  // Input requests
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [15:0]   in_tdata,   // byte_value[7:0], new_link_state[9:8], zero pad
  input  logic          in_tuser,   // op
  input  logic          in_tlast,   // last_byte
  // Results
  output logic          out_tvalid,
  input  logic          out_tready,
  // event_count[31:0], data_valid[32], link_code[34:33], engine_rpm[50:35],
  // manifold_kpa[58:51], throttle_pct[66:59], coolant_c[74:67], intake_c[82:75],
  // battery_mv[98:83], lambda_milli[114:99], ecu_uptime[146:115], zero pad
  output logic [151:0]  out_tdata,
  output logic [1:0]    out_tuser,  // outcome
  // Configuration writes
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data
);
  import tfc_pkg::*;

  logic [7:0]          start_byte_r;
  logic [7:0]          version_r;
  logic [1:0]          conn_code_r;
  logic                in_acc;
  logic                byte_en;
  verdict_t            verdict;
  logic [PayloadW-1:0] capture;
  event_t              ev;
  result_t             result;
  logic                out_valid_r;
  result_t             out_r;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      version_r    <= VERSION_RST;
      conn_code_r  <= CONN_CODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START_BYTE: start_byte_r <= cfg_data;
        CFG_VERSION:    version_r    <= cfg_data;
        CFG_CONN_CODE:  conn_code_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Input handshake: take a request whenever the result register can hold one
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign byte_en   = in_acc && (in_tuser == OP_BYTE);

  tfc_frame_track u_track (
    .clk              (clk),
    .rst_n            (rst_n),
    .byte_en          (byte_en),
    .byte_value       (in_tdata[7:0]),
    .last_byte        (in_tlast),
    .start_byte       (start_byte_r),
    .protocol_version (version_r),
    .verdict          (verdict),
    .payload          (capture)
  );

  // Event selection; header or length failure wins over checksum
  always_comb begin
    ev = EV_NONE;
    if (in_acc) begin
      if (in_tuser == OP_LINK)  ev = EV_LINK;
      else if (verdict.frame_end) begin
        if (verdict.bad_len)      ev = EV_BAD_LEN;
        else if (verdict.bad_sum) ev = EV_BAD_SUM;
        else                      ev = EV_OK;
      end
    end
  end

  tfc_status u_status (
    .clk            (clk),
    .rst_n          (rst_n),
    .ev             (ev),
    .new_link_state (in_tdata[9:8]),
    .connected_code (conn_code_r),
    .capture        (capture),
    .result         (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ev != EV_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev != EV_NONE) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.outcome;
  assign out_tdata  = {5'd0,
                       out_r.payload[111:80],   // ecu_uptime
                       out_r.payload[79:64],    // lambda_milli
                       out_r.payload[63:48],    // battery_mv
                       out_r.payload[47:40],    // intake_c
                       out_r.payload[39:32],    // coolant_c
                       out_r.payload[31:24],    // throttle_pct
                       out_r.payload[23:16],    // manifold_kpa
                       out_r.payload[15:0],     // engine_rpm
                       out_r.link,
                       out_r.valid,
                       out_r.count};

  // Checks
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled while result register empty");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_LINK || in_tlast)) |=> out_tvalid)
    else $error("final byte or link update produced no result");

  a_ok_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == OUT_OK) |-> out_tdata[32])
    else $error("good frame reported without valid data");

endmodule

### rtl/core/tfc_frame_track.sv
module tfc_frame_track (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_en,
  input  logic [7:0]                    byte_value,
  input  logic                          last_byte,
  input  logic [7:0]                    start_byte,
  input  logic [7:0]                    protocol_version,
  output tfc_pkg::verdict_t             verdict,
  output logic [tfc_pkg::PayloadW-1:0]  payload
);
  import tfc_pkg::*;

  logic [IdxW-1:0]     byte_idx_r, byte_idx_nxt;
  logic                hdr_ok_r, hdr_ok_nxt;
  logic [7:0]          xor_r, xor_nxt;
  logic [PayloadW-1:0] cap_r, cap_nxt;
  logic                in_frame;

  // Per-byte header check, running XOR and payload capture
  always_comb begin
    in_frame   = byte_idx_r < IdxW'(FrameLen);
    hdr_ok_nxt = hdr_ok_r;
    if (byte_idx_r == IdxW'(0) && byte_value != start_byte)       hdr_ok_nxt = 1'b0;
    if (byte_idx_r == IdxW'(1) && byte_value != protocol_version) hdr_ok_nxt = 1'b0;
    if (byte_idx_r == IdxW'(2) && byte_value != LENGTH_BYTE)      hdr_ok_nxt = 1'b0;
    xor_nxt      = in_frame ? (xor_r ^ byte_value) : xor_r;
    byte_idx_nxt = in_frame ? byte_idx_r + IdxW'(1) : byte_idx_r;
    cap_nxt      = cap_r;
    for (int k = 0; k < PayloadLen; k++) begin
      if (byte_idx_r == IdxW'(HeaderLen + k)) cap_nxt[8*k +: 8] = byte_value;
    end
  end

  // Verdict on a final byte; a frame shorter than FrameLen counts as bad length
  assign verdict.frame_end = last_byte;
  assign verdict.bad_len   = !hdr_ok_nxt || (byte_idx_r < IdxW'(FrameLen - 1));
  assign verdict.bad_sum   = xor_nxt != 8'd0;
  assign payload           = cap_r;

  // Tracking state; back to the start after every final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r <= '0;
      hdr_ok_r   <= 1'b1;
      xor_r      <= '0;
    end else if (byte_en) begin
      if (last_byte) begin
        byte_idx_r <= '0;
        hdr_ok_r   <= 1'b1;
        xor_r      <= '0;
      end else begin
        byte_idx_r <= byte_idx_nxt;
        hdr_ok_r   <= hdr_ok_nxt;
        xor_r      <= xor_nxt;
      end
    end
  end

  // Capture lanes; a good frame has written every lane before its final byte
  always_ff @(posedge clk) begin
    if (byte_en && !last_byte) begin
      cap_r <= cap_nxt;
    end
  end

endmodule

### rtl/core/tfc_status.sv
module tfc_status (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tfc_pkg::event_t               ev,
  input  logic [1:0]                    new_link_state,
  input  logic [1:0]                    connected_code,
  input  logic [tfc_pkg::PayloadW-1:0]  capture,
  output tfc_pkg::result_t              result
);
  import tfc_pkg::*;

  logic [PayloadW-1:0] stored_r, stored_nxt;
  logic                valid_r, valid_nxt;
  logic [1:0]          link_r, link_nxt;
  logic [31:0]         cnt_ok_r, cnt_ok_nxt;
  logic [31:0]         cnt_len_r, cnt_len_nxt;
  logic [31:0]         cnt_sum_r, cnt_sum_nxt;

  // Status update and the result that reports it
  always_comb begin
    stored_nxt     = stored_r;
    valid_nxt      = valid_r;
    link_nxt       = link_r;
    cnt_ok_nxt     = cnt_ok_r;
    cnt_len_nxt    = cnt_len_r;
    cnt_sum_nxt    = cnt_sum_r;
    result.outcome = OUT_LINK;
    result.count   = '0;
    case (ev)
      EV_LINK: begin
        link_nxt = new_link_state;
        if (new_link_state != connected_code) valid_nxt = 1'b0;
      end
      EV_BAD_LEN: begin
        cnt_len_nxt    = cnt_len_r + 32'd1;
        result.outcome = OUT_BAD_LEN;
        result.count   = cnt_len_nxt;
      end
      EV_BAD_SUM: begin
        cnt_sum_nxt    = cnt_sum_r + 32'd1;
        result.outcome = OUT_BAD_SUM;
        result.count   = cnt_sum_nxt;
      end
      EV_OK: begin
        stored_nxt     = capture;
        valid_nxt      = 1'b1;
        link_nxt       = connected_code;
        cnt_ok_nxt     = cnt_ok_r + 32'd1;
        result.outcome = OUT_OK;
        result.count   = cnt_ok_nxt;
      end
      default: ;
    endcase
    result.valid   = valid_nxt;
    result.link    = link_nxt;
    result.payload = stored_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r  <= '0;
      valid_r   <= 1'b0;
      link_r    <= '0;
      cnt_ok_r  <= '0;
      cnt_len_r <= '0;
      cnt_sum_r <= '0;
    end else begin
      stored_r  <= stored_nxt;
      valid_r   <= valid_nxt;
      link_r    <= link_nxt;
      cnt_ok_r  <= cnt_ok_nxt;
      cnt_len_r <= cnt_len_nxt;
      cnt_sum_r <= cnt_sum_nxt;
    end
  end

endmodule
